@@ rtl/least_loaded_target_selector_defines.svh @@
// Assertion macros for the least-loaded target selector.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef LEAST_LOADED_TARGET_SELECTOR_DEFINES_SVH
`define LEAST_LOADED_TARGET_SELECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LLTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LLTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LLTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LLTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/llts_pkg.sv @@
// Shared types for the least-loaded target selector: action and status codes,
// controller states. No dependencies.
package llts_pkg;

    typedef enum logic [2:0] {
        ACT_SET_LIMIT   = 3'd0,
        ACT_ACQ_TARGET  = 3'd1,
        ACT_REL_TARGET  = 3'd2,
        ACT_ADD         = 3'd3,
        ACT_REMOVE      = 3'd4,
        ACT_ACQ_GROUP   = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_BADLIM  = 3'd4,
        ST_UNDER   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCESS,
        S_MUL,
        S_CMP,
        S_GRANT
    } t_state;

endpackage

@@ rtl/llts_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module llts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/least_loaded_target_selector.sv @@
// Least-loaded target selector: target table in one RAM, group sums in registers.
// Depends on llts_pkg, llts_ram and least_loaded_target_selector_defines.svh.
//
//   channel   handshake          payload
//   request   start / busy       i_action, i_target_id, i_limit
//   result    o_done (1 cycle)   o_status, o_granted_id, o_target_load, o_group_load
//
// A named-target action is served in S_ACCESS; its result strobe is registered from that state.
// A group acquire holds busy while it scans all NUM_TARGETS entries: for each, S_MUL takes
// one RAM entry and forms two cross products and S_CMP compares them; S_GRANT then grants.
// A new request is taken in the same cycle as the previous result strobe.
// Reset clears the per-entry valid bits and the sums at once; no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "least_loaded_target_selector_defines.svh"

module least_loaded_target_selector #(
    parameter int NUM_TARGETS = 16,
    parameter int LOAD_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [3:0]  i_target_id,
    input  logic [15:0] i_limit,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [3:0]  o_granted_id,
    output logic [15:0] o_target_load,
    output logic [19:0] o_group_load
);

    localparam int IW = $clog2(NUM_TARGETS);
    localparam int LB = LOAD_BITS;
    localparam int EW = 2 * LB + 1;
    localparam int SW = LB + IW + 1;
    localparam int PW = 2 * LB;

    function automatic logic [IW-1:0] f_wrap(input logic [3:0] v);
        logic [8:0] r;
        r = {5'b0, v};
        for (int k = 0; k < 8; k++) begin
            if (r >= 9'(NUM_TARGETS)) begin
                r = r - 9'(NUM_TARGETS);
            end
        end
        return IW'(r);
    endfunction

    llts_pkg::t_state  r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [2:0]        r_action, n_action;
    logic [LB-1:0]     r_lim, n_lim;
    logic [NUM_TARGETS-1:0] r_valid, n_valid;
    logic              r_rd_ok;
    logic [SW-1:0]     r_load_sum, n_load_sum;
    logic [SW-1:0]     r_lim_sum, n_lim_sum;
    logic              r_found, n_found;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    logic [LB-1:0]     r_best_load, n_best_load;
    logic [LB-1:0]     r_best_lim, n_best_lim;
    logic [PW-1:0]     r_p1, n_p1;
    logic [PW-1:0]     r_p2, n_p2;
    logic [IW-1:0]     r_c_idx, n_c_idx;
    logic [LB-1:0]     r_c_load, n_c_load;
    logic [LB-1:0]     r_c_lim, n_c_lim;
    logic              r_c_elig, n_c_elig;
    logic              r_done, n_done;
    llts_pkg::t_status r_status, n_status;
    logic [3:0]        r_granted_id, n_granted_id;
    logic [15:0]       r_target_load, n_target_load;
    logic [19:0]       r_group_load, n_group_load;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [EW-1:0]     ram_wdata;
    logic [IW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata;

    logic [EW-1:0]     entry;
    logic              e_mem;
    logic [LB-1:0]     e_load;
    logic [LB-1:0]     e_lim;
    logic [47:0]       lim_wide;
    logic [LB-1:0]     lim_in;

    llts_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_TARGETS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign entry    = r_rd_ok ? ram_rdata : '0;
    assign e_mem    = entry[EW-1];
    assign e_load   = entry[EW-2:LB];
    assign e_lim    = entry[LB-1:0];
    assign lim_wide = {32'b0, i_limit};
    assign lim_in   = lim_wide[LB-1:0];

    always_comb begin
        llts_pkg::t_status st;
        logic              w_en;
        logic              w_mem;
        logic [LB-1:0]     w_load;
        logic [LB-1:0]     w_lim;

        n_state       = r_state;
        n_idx         = r_idx;
        n_action      = r_action;
        n_lim         = r_lim;
        n_valid       = r_valid;
        n_load_sum    = r_load_sum;
        n_lim_sum     = r_lim_sum;
        n_found       = r_found;
        n_best_idx    = r_best_idx;
        n_best_load   = r_best_load;
        n_best_lim    = r_best_lim;
        n_p1          = r_p1;
        n_p2          = r_p2;
        n_c_idx       = r_c_idx;
        n_c_load      = r_c_load;
        n_c_lim       = r_c_lim;
        n_c_elig      = r_c_elig;
        n_done        = 1'b0;
        n_status      = r_status;
        n_granted_id  = r_granted_id;
        n_target_load = r_target_load;
        n_group_load  = r_group_load;
        ram_we        = 1'b0;
        ram_waddr     = r_idx;
        ram_wdata     = entry;
        ram_raddr     = r_idx;
        st            = llts_pkg::ST_OK;
        w_en          = 1'b0;
        w_mem         = e_mem;
        w_load        = e_load;
        w_lim         = e_lim;

        unique case (r_state)
            llts_pkg::S_IDLE: begin
                if (start) begin
                    n_action    = i_action;
                    n_lim       = lim_in;
                    n_found     = 1'b0;
                    n_best_idx  = '0;
                    n_best_load = '0;
                    n_best_lim  = '0;
                    if (llts_pkg::t_action'(i_action) == llts_pkg::ACT_ACQ_GROUP) begin
                        n_idx     = '0;
                        ram_raddr = '0;
                        n_state   = llts_pkg::S_MUL;
                    end else begin
                        n_idx     = f_wrap(i_target_id);
                        ram_raddr = f_wrap(i_target_id);
                        n_state   = llts_pkg::S_ACCESS;
                    end
                end
            end
            llts_pkg::S_ACCESS: begin
                unique case (llts_pkg::t_action'(r_action))
                    llts_pkg::ACT_SET_LIMIT: begin
                        if (r_lim == '0) begin
                            st = llts_pkg::ST_BADLIM;
                        end else begin
                            if (e_mem) begin
                                n_lim_sum  = r_lim_sum - SW'(e_lim) + SW'(r_lim);
                                n_load_sum = r_load_sum - SW'(e_load);
                            end
                            w_lim  = r_lim;
                            w_load = '0;
                            w_en   = 1'b1;
                        end
                    end
                    llts_pkg::ACT_ACQ_TARGET: begin
                        if (e_load >= e_lim) begin
                            st = llts_pkg::ST_FULL;
                        end else begin
                            w_load = e_load + 1'b1;
                            w_en   = 1'b1;
                            if (e_mem) begin
                                n_load_sum = r_load_sum + 1'b1;
                            end
                        end
                    end
                    llts_pkg::ACT_REL_TARGET: begin
                        if (e_load == '0) begin
                            st = llts_pkg::ST_UNDER;
                        end else begin
                            w_load = e_load - 1'b1;
                            w_en   = 1'b1;
                            if (e_mem) begin
                                n_load_sum = r_load_sum - 1'b1;
                            end
                        end
                    end
                    llts_pkg::ACT_ADD: begin
                        if (e_mem) begin
                            st = llts_pkg::ST_DUP;
                        end else begin
                            w_mem      = 1'b1;
                            w_en       = 1'b1;
                            n_lim_sum  = r_lim_sum + SW'(e_lim);
                            n_load_sum = r_load_sum + SW'(e_load);
                        end
                    end
                    llts_pkg::ACT_REMOVE: begin
                        if (!e_mem) begin
                            st = llts_pkg::ST_ABSENT;
                        end else begin
                            w_mem      = 1'b0;
                            w_en       = 1'b1;
                            n_lim_sum  = r_lim_sum - SW'(e_lim);
                            n_load_sum = r_load_sum - SW'(e_load);
                        end
                    end
                    default: begin
                        st = llts_pkg::ST_OK;
                    end
                endcase
                ram_we    = w_en;
                ram_waddr = r_idx;
                ram_wdata = {w_mem, w_load, w_lim};
                if (w_en) begin
                    n_valid[r_idx] = 1'b1;
                end
                n_done        = 1'b1;
                n_status      = st;
                n_granted_id  = 4'(r_idx);
                n_target_load = 16'(w_load);
                n_group_load  = 20'(n_load_sum);
                n_state       = llts_pkg::S_IDLE;
            end
            llts_pkg::S_MUL: begin
                n_p1     = PW'(e_load) * PW'(r_best_lim);
                n_p2     = PW'(r_best_load) * PW'(e_lim);
                n_c_idx  = r_idx;
                n_c_load = e_load;
                n_c_lim  = e_lim;
                n_c_elig = e_mem && (e_load < e_lim);
                n_state  = llts_pkg::S_CMP;
            end
            llts_pkg::S_CMP: begin
                if (r_c_elig && (!r_found || (r_p1 < r_p2))) begin
                    n_found     = 1'b1;
                    n_best_idx  = r_c_idx;
                    n_best_load = r_c_load;
                    n_best_lim  = r_c_lim;
                end
                if (r_idx == IW'(NUM_TARGETS - 1)) begin
                    n_state = llts_pkg::S_GRANT;
                end else begin
                    n_idx     = r_idx + 1'b1;
                    ram_raddr = r_idx + 1'b1;
                    n_state   = llts_pkg::S_MUL;
                end
            end
            llts_pkg::S_GRANT: begin
                n_done = 1'b1;
                if (r_found && (r_load_sum < r_lim_sum)) begin
                    ram_we                  = 1'b1;
                    ram_waddr               = r_best_idx;
                    ram_wdata               = {1'b1, r_best_load + 1'b1, r_best_lim};
                    n_valid[r_best_idx]     = 1'b1;
                    n_load_sum              = r_load_sum + 1'b1;
                    n_status                = llts_pkg::ST_OK;
                    n_granted_id            = 4'(r_best_idx);
                    n_target_load           = 16'(r_best_load + 1'b1);
                    n_group_load            = 20'(r_load_sum + 1'b1);
                end else begin
                    n_status      = llts_pkg::ST_FULL;
                    n_granted_id  = '0;
                    n_target_load = '0;
                    n_group_load  = 20'(r_load_sum);
                end
                n_state = llts_pkg::S_IDLE;
            end
            default: begin
                n_state = llts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= llts_pkg::S_IDLE;
            r_valid    <= '0;
            r_load_sum <= '0;
            r_lim_sum  <= '0;
            r_done     <= 1'b0;
            r_found    <= 1'b0;
            r_rd_ok    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_load_sum <= n_load_sum;
            r_lim_sum  <= n_lim_sum;
            r_done     <= n_done;
            r_found    <= n_found;
            r_rd_ok    <= r_valid[ram_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_action      <= n_action;
        r_lim         <= n_lim;
        r_best_idx    <= n_best_idx;
        r_best_load   <= n_best_load;
        r_best_lim    <= n_best_lim;
        r_p1          <= n_p1;
        r_p2          <= n_p2;
        r_c_idx       <= n_c_idx;
        r_c_load      <= n_c_load;
        r_c_lim       <= n_c_lim;
        r_c_elig      <= n_c_elig;
        r_status      <= n_status;
        r_granted_id  <= n_granted_id;
        r_target_load <= n_target_load;
        r_group_load  <= n_group_load;
    end

    assign busy          = (r_state != llts_pkg::S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_granted_id  = r_granted_id;
    assign o_target_load = r_target_load;
    assign o_group_load  = r_group_load;

    `LLTS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "no busy after accept")
    `LLTS_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "strobe while busy")
    `LLTS_ASSERT_IMP(a_sum_bound, i_clk, i_rst_n, 1'b1, r_load_sum <= r_lim_sum, "load sum high")

endmodule

@@ bench/tb_least_loaded_target_selector.sv @@
// Testbench for least_loaded_target_selector: a queue-fed driver, a result monitor and a
// cycle-free predictor of the target table and group sums. Depends on llts_pkg and the RTL.
`timescale 1ns / 1ps

module tb_least_loaded_target_selector;

    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam int N_RANDOM = 1050;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  target_id;
        logic [15:0] limit;
    } t_request;

    typedef struct packed {
        llts_pkg::t_status status;
        logic [3:0]        granted_id;
        logic [15:0]       target_load;
        logic [19:0]       group_load;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_action = '0;
    logic [3:0]  i_target_id = '0;
    logic [15:0] i_limit = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic [3:0]  o_granted_id;
    logic [15:0] o_target_load;
    logic [19:0] o_group_load;

    logic [15:0] slot_limit [16];
    logic [15:0] slot_load [16];
    bit          in_group [16];
    logic [20:0] grp_load = '0;
    logic [20:0] grp_limit = '0;

    t_request pending_requests[$];
    t_grant   expected_grants[$];
    t_request cur_req;
    int       n_total = 0;
    int       n_accepted = 0;
    int       n_errors = 0;

    least_loaded_target_selector dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_target_id  (i_target_id),
        .i_limit      (i_limit),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_granted_id (o_granted_id),
        .o_target_load(o_target_load),
        .o_group_load (o_group_load)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_request mk(logic [2:0] act, logic [3:0] id, logic [15:0] lim);
        t_request rq;
        rq.action = act;
        rq.target_id = id;
        rq.limit = lim;
        return rq;
    endfunction

    function automatic t_grant apply_request(t_request rq);
        t_grant      res;
        logic [3:0]  id;
        logic [3:0]  best;
        bit          found;
        logic [31:0] lhs;
        logic [31:0] rhs;
        id = rq.target_id;
        res.status = llts_pkg::ST_OK;
        best = '0;
        found = 1'b0;
        case (rq.action)
            llts_pkg::ACT_SET_LIMIT: begin
                if (rq.limit == 16'd0) begin
                    res.status = llts_pkg::ST_BADLIM;
                end else begin
                    if (in_group[id]) begin
                        grp_limit = grp_limit - slot_limit[id] + rq.limit;
                        grp_load = grp_load - slot_load[id];
                    end
                    slot_limit[id] = rq.limit;
                    slot_load[id] = '0;
                end
            end
            llts_pkg::ACT_ACQ_TARGET: begin
                if (slot_load[id] >= slot_limit[id]) begin
                    res.status = llts_pkg::ST_FULL;
                end else begin
                    slot_load[id]++;
                    if (in_group[id]) grp_load++;
                end
            end
            llts_pkg::ACT_REL_TARGET: begin
                if (slot_load[id] == 16'd0) begin
                    res.status = llts_pkg::ST_UNDER;
                end else begin
                    slot_load[id]--;
                    if (in_group[id]) grp_load--;
                end
            end
            llts_pkg::ACT_ADD: begin
                if (in_group[id]) begin
                    res.status = llts_pkg::ST_DUP;
                end else begin
                    in_group[id] = 1'b1;
                    grp_limit = grp_limit + slot_limit[id];
                    grp_load = grp_load + slot_load[id];
                end
            end
            llts_pkg::ACT_REMOVE: begin
                if (!in_group[id]) begin
                    res.status = llts_pkg::ST_ABSENT;
                end else begin
                    in_group[id] = 1'b0;
                    grp_limit = grp_limit - slot_limit[id];
                    grp_load = grp_load - slot_load[id];
                end
            end
            llts_pkg::ACT_ACQ_GROUP: begin
                if (grp_load < grp_limit) begin
                    for (int i = 0; i < 16; i++) begin
                        if (in_group[i] && slot_load[i] < slot_limit[i]) begin
                            lhs = slot_load[i] * slot_limit[best];
                            rhs = slot_load[best] * slot_limit[i];
                            if (!found || lhs < rhs) begin
                                best = 4'(i);
                                found = 1'b1;
                            end
                        end
                    end
                end
                if (!found) begin
                    res.status = llts_pkg::ST_FULL;
                    res.granted_id = '0;
                    res.target_load = '0;
                    res.group_load = grp_load[19:0];
                    return res;
                end
                slot_load[best]++;
                grp_load++;
                id = best;
            end
            default: ;
        endcase
        res.granted_id = id;
        res.target_load = slot_load[id];
        res.group_load = grp_load[19:0];
        return res;
    endfunction

    task automatic note_failure(string msg);
        n_errors++;
        if (n_errors <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : driver
        int idle_pct;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_grants.push_back(apply_request(cur_req));
                n_accepted++;
            end
            if (!start || !busy) begin
                if (n_accepted < n_total / 3) idle_pct = 19;
                else if (n_accepted < 2 * n_total / 3) idle_pct = 59;
                else idle_pct = 0;
                if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    cur_req = pending_requests.pop_front();
                    start <= 1'b1;
                    i_action <= cur_req.action;
                    i_target_id <= cur_req.target_id;
                    i_limit <= cur_req.limit;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_grant want;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_grants.size() == 0) begin
                note_failure($sformatf("unexpected result: status %0d id %0d load %0d group %0d",
                    o_status, o_granted_id, o_target_load, o_group_load));
            end else begin
                want = expected_grants.pop_front();
                if (o_status !== want.status || o_granted_id !== want.granted_id ||
                    o_target_load !== want.target_load || o_group_load !== want.group_load) begin
                    note_failure($sformatf(
                        "mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                        want.status, want.granted_id, want.target_load, want.group_load,
                        o_status, o_granted_id, o_target_load, o_group_load));
                end
            end
        end
    end

    initial begin : stimulus
        int       r;
        t_request rq;
        for (int i = 0; i < 16; i++) begin
            slot_limit[i] = '0;
            slot_load[i] = '0;
            in_group[i] = 1'b0;
        end

        pending_requests.push_back(mk(llts_pkg::ACT_SET_LIMIT, 4'd0, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_SET_LIMIT, 4'd15, 16'hFFFF));
        pending_requests.push_back(mk(llts_pkg::ACT_SET_LIMIT, 4'd0, 16'd1));
        pending_requests.push_back(mk(llts_pkg::ACT_ACQ_TARGET, 4'd0, 16'hFFFF));
        pending_requests.push_back(mk(llts_pkg::ACT_ACQ_TARGET, 4'd0, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_REL_TARGET, 4'd0, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_REL_TARGET, 4'd0, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_ADD, 4'd0, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_ADD, 4'd0, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_REMOVE, 4'd3, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_ACQ_GROUP, 4'd9, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_ACQ_GROUP, 4'd0, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_ADD, 4'd15, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_ACQ_GROUP, 4'd0, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_SET_LIMIT, 4'd0, 16'd2));
        pending_requests.push_back(mk(llts_pkg::ACT_SET_LIMIT, 4'd1, 16'd2));
        pending_requests.push_back(mk(llts_pkg::ACT_ADD, 4'd1, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_ACQ_GROUP, 4'd15, 16'hFFFF));
        pending_requests.push_back(mk(llts_pkg::ACT_ADD, 4'd7, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_REMOVE, 4'd15, 16'd0));
        pending_requests.push_back(mk(ACT_SPARE_6, 4'd15, 16'hAAAA));
        pending_requests.push_back(mk(ACT_SPARE_7, 4'd0, 16'h5555));
        pending_requests.push_back(mk(llts_pkg::ACT_REMOVE, 4'd0, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_REMOVE, 4'd1, 16'd0));
        pending_requests.push_back(mk(llts_pkg::ACT_ACQ_GROUP, 4'd0, 16'd0));

        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 12) rq.action = llts_pkg::ACT_SET_LIMIT;
            else if (r < 30) rq.action = llts_pkg::ACT_ACQ_TARGET;
            else if (r < 45) rq.action = llts_pkg::ACT_REL_TARGET;
            else if (r < 57) rq.action = llts_pkg::ACT_ADD;
            else if (r < 65) rq.action = llts_pkg::ACT_REMOVE;
            else if (r < 95) rq.action = llts_pkg::ACT_ACQ_GROUP;
            else rq.action = ($urandom_range(0, 1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7;
            rq.target_id = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 5))
                                                       : 4'($urandom_range(0, 15));
            r = $urandom_range(0, 99);
            if (rq.action != llts_pkg::ACT_SET_LIMIT) rq.limit = 16'($urandom_range(0, 65535));
            else if (r < 70) rq.limit = 16'($urandom_range(1, 8));
            else if (r < 78) rq.limit = 16'd0;
            else if (r < 88) rq.limit = 16'hFFFF;
            else rq.limit = 16'($urandom_range(0, 65535));
            pending_requests.push_back(rq);
        end
        n_total = pending_requests.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_requests.size() > 0 || start || expected_grants.size() > 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (expected_grants.size() > 0) note_failure("results missing at end of run");
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/llts_pkg.sv
rtl/llts_ram.sv
rtl/least_loaded_target_selector.sv
bench/tb_least_loaded_target_selector.sv
